### rtl/lstp_pkg.sv
// Package: shared types and constants for the scan-to-points filter.
package lstp_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [2:0] REG_XOFF  = 3'd0;
    localparam logic [2:0] REG_YOFF  = 3'd1;
    localparam logic [2:0] REG_MOUNT = 3'd2;
    localparam logic [2:0] REG_WLO   = 3'd3;
    localparam logic [2:0] REG_WHI   = 3'd4;
    localparam logic [2:0] REG_FLAGS = 3'd5;
    localparam logic [2:0] REG_HLEN  = 3'd6;
    localparam logic [2:0] REG_HWID  = 3'd7;

    localparam int FLAG_SHOW = 0;
    localparam int FLAG_FLIP = 1;
    localparam int FLAG_INV  = 2;

    typedef struct packed {
        logic signed [20:0] xoff;
        logic signed [20:0] yoff;
        logic [23:0]        mount;
        logic signed [24:0] wlo;
        logic signed [24:0] whi;
        logic [2:0]         flags;
        logic [19:0]        hlen;
        logic [19:0]        hwid;
    } cfg_t;

    // work item handed from front to back
    typedef struct packed {
        logic [19:0] range;
        logic [11:0] pos;
        logic [1:0]  quad;
        logic signed [33:0] z;
    } job_t;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 34'sd536870912;
            5'd1:  atan_turn = 34'sd316933406;
            5'd2:  atan_turn = 34'sd167458907;
            5'd3:  atan_turn = 34'sd85004756;
            5'd4:  atan_turn = 34'sd42667331;
            5'd5:  atan_turn = 34'sd21354465;
            5'd6:  atan_turn = 34'sd10679838;
            5'd7:  atan_turn = 34'sd5340245;
            5'd8:  atan_turn = 34'sd2670163;
            5'd9:  atan_turn = 34'sd1335087;
            5'd10: atan_turn = 34'sd667544;
            5'd11: atan_turn = 34'sd333772;
            5'd12: atan_turn = 34'sd166886;
            5'd13: atan_turn = 34'sd83443;
            5'd14: atan_turn = 34'sd41722;
            5'd15: atan_turn = 34'sd20861;
            5'd16: atan_turn = 34'sd10430;
            5'd17: atan_turn = 34'sd5215;
            5'd18: atan_turn = 34'sd2608;
            5'd19: atan_turn = 34'sd1304;
            5'd20: atan_turn = 34'sd652;
            5'd21: atan_turn = 34'sd326;
            5'd22: atan_turn = 34'sd163;
            5'd23: atan_turn = 34'sd81;
            5'd24: atan_turn = 34'sd41;
            5'd25: atan_turn = 34'sd20;
            5'd26: atan_turn = 34'sd10;
            5'd27: atan_turn = 34'sd5;
            default: atan_turn = 34'sd0;
        endcase
    endfunction

endpackage

### rtl/lstp_front.sv
// Front: angle computation, drop tests and phase reduction, two stages.
module lstp_front
    import lstp_pkg::*;
#(
    parameter int LEN_W = 13
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [19:0]       range_value,
    input  logic              range_invalid,
    input  logic [11:0]       array_position,
    input  logic [LEN_W-1:0]  scan_length,
    input  logic signed [24:0] bound_a,
    input  logic signed [24:0] bound_b,
    input  logic [19:0]       angle_step,
    input  logic [19:0]       range_floor,
    input  logic [19:0]       range_ceiling,
    input  logic              max_ok,
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    logic              s1_v_reg;
    logic [19:0]       s1_r_reg;
    logic [11:0]       s1_pos_reg;
    logic signed [24:0] s1_lo_reg, s1_hi_reg;
    logic [LEN_W-1:0]  s1_beam_reg;
    logic [19:0]       s1_step_reg;
    logic              s1_ok_reg;

    logic              s2_v_reg;
    job_t              s2_job_reg;

    logic advance1, advance2;
    assign advance2 = !s2_v_reg || job_ready;
    assign advance1 = !s1_v_reg || advance2;
    assign in_ready = advance1;

    logic signed [24:0] lo_c, hi_c;
    logic [LEN_W-1:0] pos_ext, beam_c;
    logic ok_c;
    always_comb
    begin
        lo_c = (bound_a < bound_b) ? bound_a : bound_b;
        hi_c = (bound_a < bound_b) ? bound_b : bound_a;
        pos_ext = LEN_W'(array_position);
        beam_c = cfg.flags[FLAG_FLIP] ? (scan_length - LEN_W'(1) - pos_ext) : pos_ext;
        ok_c = cfg.flags[FLAG_SHOW] && max_ok && (pos_ext < scan_length)
            && !range_invalid && (range_value >= range_floor)
            && (range_value <= range_ceiling);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (advance1)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance1)
        begin
            s1_r_reg    <= range_value;
            s1_pos_reg  <= array_position;
            s1_lo_reg   <= lo_c;
            s1_hi_reg   <= hi_c;
            s1_beam_reg <= beam_c;
            s1_step_reg <= angle_step;
            s1_ok_reg   <= ok_c;
        end
    end

    // stage 2: angle = lo + beam*step, exact
    localparam int PW = LEN_W + 21;
    localparam int AW = PW + 2;
    logic [PW-1:0] prod_c;
    logic signed [AW-1:0] angle_c;
    logic in_win, keep;
    logic [23:0] phase;
    logic [1:0] q;
    logic signed [24:0] res;
    always_comb
    begin
        prod_c = PW'(s1_beam_reg) * PW'(s1_step_reg);
        angle_c = AW'(s1_lo_reg) + AW'(signed'({1'b0, prod_c}));
        in_win = (angle_c >= AW'(cfg.wlo)) && (angle_c <= AW'(cfg.whi));
        keep = s1_ok_reg && (angle_c <= AW'(s1_hi_reg)) && (in_win != cfg.flags[FLAG_INV]);
        phase = angle_c[23:0] + cfg.mount;
        q = 2'(({1'b0, phase} + 25'd2097152) >> 22);
        res = signed'({1'b0, phase}) - signed'(25'({q, 22'd0}));
        if (phase >= 24'hE00000 && q == 2'd0)
            res = signed'({1'b0, phase}) - 25'sh1000000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (advance2)
            s2_v_reg <= s1_v_reg && keep;
    end

    always_ff @(posedge clk)
    begin
        if (advance2)
        begin
            s2_job_reg.range <= s1_r_reg;
            s2_job_reg.pos   <= s1_pos_reg;
            s2_job_reg.quad  <= q;
            s2_job_reg.z     <= 34'(res) <<< 8;
        end
    end

    assign job_valid = s2_v_reg;
    assign job = s2_job_reg;

endmodule

### rtl/lstp_queue.sv
// Two-entry queue between front and back.
module lstp_queue
    import lstp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);
    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;
    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

### rtl/lstp_back.sv
// Back: pipelined CORDIC, projection, offset, footprint test and output register.
module lstp_back
    import lstp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [21:0] out_x,
    output logic signed [21:0] out_y,
    output logic [11:0] out_pos
);
    localparam int N = CORDIC_STEPS;

    logic advance;
    logic out_v_reg;
    assign advance = !out_v_reg || out_ready;
    assign job_ready = advance;

    logic v_reg [N+1];
    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic [19:0] r_reg [N+1];
    logic [11:0] p_reg [N+1];
    logic [1:0] q_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (advance)
            v_reg[0] <= job_valid;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= job.z;
            r_reg[0] <= job.range;
            p_reg[0] <= job.pos;
            q_reg[0] <= job.quad;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (advance)
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_turn(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_turn(5'(i));
                end
                r_reg[i+1] <= r_reg[i];
                p_reg[i+1] <= p_reg[i];
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // quadrant fix and multiply
    logic signed [33:0] c_c, s_c;
    always_comb
    begin
        case (q_reg[N])
            2'd0: begin c_c = x_reg[N];  s_c = y_reg[N];  end
            2'd1: begin c_c = -y_reg[N]; s_c = x_reg[N];  end
            2'd2: begin c_c = -x_reg[N]; s_c = -y_reg[N]; end
            default: begin c_c = y_reg[N]; s_c = -x_reg[N]; end
        endcase
    end

    logic m_v_reg;
    logic signed [54:0] mx_reg, my_reg;
    logic [11:0] m_p_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (advance)
            m_v_reg <= v_reg[N];
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mx_reg <= signed'({1'b0, r_reg[N]}) * c_c;
            my_reg <= signed'({1'b0, r_reg[N]}) * s_c;
            m_p_reg <= p_reg[N];
        end
    end

    function automatic logic signed [21:0] proj(input logic signed [54:0] m,
                                                input logic signed [20:0] off);
        logic signed [26:0] v;
        begin
            v = 27'((m + 55'sd536870912) >>> 30) + 27'(off);
            if (v > 27'sd2097151) proj = 22'sd2097151;
            else if (v < -27'sd2097152) proj = -22'sd2097152;
            else proj = 22'(v);
        end
    endfunction

    logic signed [21:0] px_c, py_c;
    logic [21:0] ax, ay;
    logic in_box;
    always_comb
    begin
        px_c = proj(mx_reg, cfg.xoff);
        py_c = proj(my_reg, cfg.yoff);
        ax = px_c[21] ? 22'(-px_c) : 22'(px_c);
        ay = py_c[21] ? 22'(-py_c) : 22'(py_c);
        in_box = (ax <= 22'(cfg.hlen)) && (ay <= 22'(cfg.hwid));
    end

    logic signed [21:0] ox_reg, oy_reg;
    logic [11:0] op_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= m_v_reg && !in_box;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ox_reg <= px_c;
            oy_reg <= py_c;
            op_reg <= m_p_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_pos = op_reg;
endmodule

### rtl/lidar_scan_to_points_filter.sv
// Top level: laser scan sample to 2D point projection with footprint filter.
// Usage:
//  s_axis carries one range sample per transfer; m_axis gives a point for
//  each sample that passes all tests, none for a dropped sample.
//  cfg_valid/cfg_ready write the registers (index 0..7); write only when idle.
//  Throughput: one sample per cycle while m_axis_tready holds. The path to
//  output valid is registered in two front stages, queue, back input
//  register, 28 CORDIC stages, multiply and output register, the first of
//  them loaded at the input transfer edge.
//  When the m_axis receiver stalls, the back pipeline holds, the two-entry
//  queue fills, then the front and s_axis_tready stall.
//  Reset clears all valid flags and loads register reset values.
//  Samples with scan_length above MAX_SAMPLES are dropped.
module lidar_scan_to_points_filter
    import lstp_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // range_value[19:0] range_invalid[20] array_position[32:21]
    // scan_length[45:33] scan_bound_a[70:46] scan_bound_b[95:71]
    // angle_step[115:96] range_floor[135:116] range_ceiling[155:136]
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // point_x[21:0] point_y[43:22] source_position[55:44]
    output logic [55:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [24:0]  cfg_data
);
    cfg_t cfg_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.xoff  <= '0;
            cfg_reg.yoff  <= '0;
            cfg_reg.mount <= '0;
            cfg_reg.wlo   <= -25'sd8435211;
            cfg_reg.whi   <= 25'sd8435211;
            cfg_reg.flags <= 3'd1;
            cfg_reg.hlen  <= 20'd2310;
            cfg_reg.hwid  <= 20'd1634;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_XOFF:  cfg_reg.xoff  <= cfg_data[20:0];
                REG_YOFF:  cfg_reg.yoff  <= cfg_data[20:0];
                REG_MOUNT: cfg_reg.mount <= cfg_data[23:0];
                REG_WLO:   cfg_reg.wlo   <= cfg_data;
                REG_WHI:   cfg_reg.whi   <= cfg_data;
                REG_FLAGS: cfg_reg.flags <= cfg_data[2:0];
                REG_HLEN:  cfg_reg.hlen  <= cfg_data[19:0];
                REG_HWID:  cfg_reg.hwid  <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    logic [12:0] len;
    logic max_ok;
    assign len = s_axis_tdata[45:33];
    assign max_ok = 32'(len) <= 32'(MAX_SAMPLES);

    logic jf_valid, jf_ready, jb_valid, jb_ready;
    job_t jf, jb;

    lstp_front #(.LEN_W(13)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .range_value(s_axis_tdata[19:0]), .range_invalid(s_axis_tdata[20]),
        .array_position(s_axis_tdata[32:21]), .scan_length(len),
        .bound_a(s_axis_tdata[70:46]), .bound_b(s_axis_tdata[95:71]),
        .angle_step(s_axis_tdata[115:96]), .range_floor(s_axis_tdata[135:116]),
        .range_ceiling(s_axis_tdata[155:136]), .max_ok(max_ok),
        .job_valid(jf_valid), .job_ready(jf_ready), .job(jf)
    );

    lstp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(jf_valid), .wr_ready(jf_ready), .wr_data(jf),
        .rd_valid(jb_valid), .rd_ready(jb_ready), .rd_data(jb)
    );

    logic signed [21:0] ox, oy;
    logic [11:0] op;
    lstp_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .job_valid(jb_valid), .job_ready(jb_ready), .job(jb),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_x(ox), .out_y(oy), .out_pos(op)
    );

    assign m_axis_tdata = {op, oy, ox};
endmodule

### rtl/lstp_checker.sv
// Checker: port-level assertions for the scan-to-points filter, with bind.
module lstp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid || rst_n)
        else $error("output valid during reset");
endmodule

bind lidar_scan_to_points_filter lstp_checker u_lstp_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_ready(cfg_ready)
);
